### rtl/core/isotx_pkg.sv
// Package for the ISO transmit header and credit table block.
// Holds field widths, table depth, status and opcode codes and the result type.
// No dependencies.
package isotx_pkg;

   localparam int MAX_CONNECTIONS = 5;
   localparam int ENTRY_CNT_W     = $clog2(MAX_CONNECTIONS + 1);

   localparam int HANDLE_W = 12;
   localparam int SEQ_W    = 16;
   localparam int SDU_W    = 16;
   localparam int COUNT_W  = 16;
   localparam int STATUS_W = 3;
   localparam int WORD_W   = 16;
   localparam int LOAD_W   = 14;
   localparam int SDU_OUT_W = 12;
   localparam int MAXLEN_W = 12;

   localparam logic [MAXLEN_W-1:0] MAX_DATA_LEN_RESET = 12'hFFF;
   localparam logic [1:0]          PB_COMPLETE        = 2'd2;
   localparam logic [LOAD_W-1:0]   TS_HDR_LEN         = 14'd8;
   localparam logic [LOAD_W-1:0]   NO_TS_HDR_LEN      = 14'd4;
   localparam logic [COUNT_W-1:0]  COUNT_MAX          = 16'hFFFF;

   typedef enum logic {
      OP_SEND   = 1'b0,
      OP_REPORT = 1'b1
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK       = 3'd0,
      STATUS_TOO_LONG = 3'd1,
      STATUS_UNKNOWN  = 3'd2,
      STATUS_FULL     = 3'd3,
      STATUS_SKIPPED  = 3'd4
   } status_type;

   typedef struct packed {
      status_type            status;
      logic [WORD_W-1:0]     flags_handle_word;
      logic [LOAD_W-1:0]     load_length;
      logic [SEQ_W-1:0]      seq_out;
      logic [SDU_OUT_W-1:0]  sdu_len_out;
      logic [COUNT_W-1:0]    outstanding;
      logic [COUNT_W-1:0]    released_count;
   } result_type;

endpackage

### rtl/core/iso_tx_header_and_credit_table.sv
// Top level: ISO transmit header builder with per-connection outstanding count table.
// Depends on isotx_pkg.
//
//   channel  direction  handshake          payload
//   req_     in         valid / stall      opcode, handle, seq, ts, sdu, count, last
//   rsp_     out        valid / stall      status, header fields, outstanding, released
//   csr_     in         valid / ready      max_data_len (12 bits)
//
// One item per cycle while req_stall is low; its result goes to the result register,
// or to the skid while that register is held. The table lookup (all entries compared
// in parallel) and the count update are combinational between the input ports and the
// result register. A two-entry output (result register plus skid) keeps input open
// while one result waits; req_stall rises only when both are held. Synchronous reset
// clears the table valid bits, entry count, abort flag and both output valid flags.
module iso_tx_header_and_credit_table (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_opcode,
   input  logic [isotx_pkg::HANDLE_W-1:0]     req_conn_handle,
   input  logic [isotx_pkg::SEQ_W-1:0]        req_seq_number,
   input  logic                               req_ts_present,
   input  logic [isotx_pkg::SDU_W-1:0]        req_sdu_length,
   input  logic [isotx_pkg::COUNT_W-1:0]      req_completed_count,
   input  logic                               req_last_pair,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [isotx_pkg::STATUS_W-1:0]     rsp_status,
   output logic [isotx_pkg::WORD_W-1:0]       rsp_flags_handle_word,
   output logic [isotx_pkg::LOAD_W-1:0]       rsp_load_length,
   output logic [isotx_pkg::SEQ_W-1:0]        rsp_seq_out,
   output logic [isotx_pkg::SDU_OUT_W-1:0]    rsp_sdu_len_out,
   output logic [isotx_pkg::COUNT_W-1:0]      rsp_outstanding,
   output logic [isotx_pkg::COUNT_W-1:0]      rsp_released_count,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [isotx_pkg::MAXLEN_W-1:0]     csr_data
);
   import isotx_pkg::*;

   logic [MAXLEN_W-1:0]    max_data_len_ff;
   logic [HANDLE_W-1:0]    handle_table_ff [MAX_CONNECTIONS];
   logic [COUNT_W-1:0]     count_ff [MAX_CONNECTIONS];
   logic [MAX_CONNECTIONS-1:0] valid_ff;
   logic [ENTRY_CNT_W-1:0] entries_used_ff;
   logic                   aborted_ff;

   logic [MAX_CONNECTIONS-1:0] valid_in;
   logic [ENTRY_CNT_W-1:0] entries_used_in;
   logic                   aborted_in;
   logic [MAX_CONNECTIONS-1:0] wr_sel;
   logic [COUNT_W-1:0]     wr_count;

   result_type             out_ff, skid_ff, result;
   logic                   out_valid_ff, skid_valid_ff;

   logic                   req_xfer, rsp_xfer;
   logic [MAX_CONNECTIONS-1:0] match, free_oh;
   logic                   found, table_full;
   logic [COUNT_W-1:0]     found_count;

   assign req_xfer  = req_valid && !req_stall;
   assign rsp_xfer  = out_valid_ff && !rsp_stall;
   assign req_stall = skid_valid_ff;
   assign csr_ready = 1'b1;

   // Handles are unique in the table, so at most one match.
   always_comb begin
      found_count = '0;
      for (int i = 0; i < MAX_CONNECTIONS; i++) begin
         match[i] = valid_ff[i] && (handle_table_ff[i] == req_conn_handle);
         if (match[i]) begin
            found_count = found_count | count_ff[i];
         end
      end
   end

   assign found      = |match;
   // lowest clear bit of the valid vector
   assign free_oh    = ~valid_ff & (valid_ff + MAX_CONNECTIONS'(1));
   assign table_full = (entries_used_ff == ENTRY_CNT_W'(MAX_CONNECTIONS));

   always_comb begin
      result          = '0;
      result.status   = STATUS_OK;
      valid_in        = valid_ff;
      entries_used_in = entries_used_ff;
      aborted_in      = aborted_ff;
      wr_sel          = '0;
      wr_count        = '0;
      if (req_opcode == OP_SEND) begin
         if (req_sdu_length > {{(SDU_W-MAXLEN_W){1'b0}}, max_data_len_ff}) begin
            result.status = STATUS_TOO_LONG;
         end else begin
            result.flags_handle_word = {1'b0, req_ts_present, PB_COMPLETE, req_conn_handle};
            result.load_length = req_sdu_length[LOAD_W-1:0] +
                                 (req_ts_present ? TS_HDR_LEN : NO_TS_HDR_LEN);
            result.seq_out     = req_seq_number;
            result.sdu_len_out = req_sdu_length[SDU_OUT_W-1:0];
            if (found) begin
               wr_sel   = match;
               wr_count = (found_count == COUNT_MAX) ? found_count
                                                     : found_count + COUNT_W'(1);
               result.outstanding = wr_count;
            end else if (table_full) begin
               result.status = STATUS_FULL;
            end else begin
               wr_sel          = free_oh;
               wr_count        = COUNT_W'(1);
               valid_in        = valid_ff | free_oh;
               entries_used_in = entries_used_ff + ENTRY_CNT_W'(1);
               result.outstanding = wr_count;
            end
         end
      end else begin
         if (aborted_ff) begin
            result.status = STATUS_SKIPPED;
         end else if (found) begin
            wr_sel   = match;
            wr_count = (found_count >= req_completed_count) ?
                       found_count - req_completed_count : '0;
            result.outstanding    = wr_count;
            result.released_count = req_completed_count;
         end else begin
            result.status = STATUS_UNKNOWN;
            aborted_in    = 1'b1;
         end
         if (req_last_pair) begin
            aborted_in = 1'b0;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         max_data_len_ff <= MAX_DATA_LEN_RESET;
         valid_ff        <= '0;
         entries_used_ff <= '0;
         aborted_ff      <= 1'b0;
         out_valid_ff    <= 1'b0;
         skid_valid_ff   <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            max_data_len_ff <= csr_data;
         end
         if (req_xfer) begin
            valid_ff        <= valid_in;
            entries_used_ff <= entries_used_in;
            aborted_ff      <= aborted_in;
         end
         if (skid_valid_ff) begin
            if (rsp_xfer) begin
               skid_valid_ff <= 1'b0;
            end
         end else if (req_xfer) begin
            if (out_valid_ff && !rsp_xfer) begin
               skid_valid_ff <= 1'b1;
            end else begin
               out_valid_ff <= 1'b1;
            end
         end else if (rsp_xfer) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // table contents and result payload, no reset
   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_CONNECTIONS; i++) begin
         if (req_xfer && wr_sel[i]) begin
            count_ff[i]        <= wr_count;
            handle_table_ff[i] <= req_conn_handle;
         end
      end
      if (skid_valid_ff) begin
         if (rsp_xfer) begin
            out_ff <= skid_ff;
         end
      end else if (req_xfer) begin
         if (out_valid_ff && !rsp_xfer) begin
            skid_ff <= result;
         end else begin
            out_ff <= result;
         end
      end
   end

   assign rsp_valid             = out_valid_ff;
   assign rsp_status            = out_ff.status;
   assign rsp_flags_handle_word = out_ff.flags_handle_word;
   assign rsp_load_length       = out_ff.load_length;
   assign rsp_seq_out           = out_ff.seq_out;
   assign rsp_sdu_len_out       = out_ff.sdu_len_out;
   assign rsp_outstanding       = out_ff.outstanding;
   assign rsp_released_count    = out_ff.released_count;

`ifndef SYNTH
   a_skid_behind_out : assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid holds a result while the output register is empty");

   a_used_matches_valid : assert property (@(posedge clock) disable iff (reset)
      $countones(valid_ff) == int'(entries_used_ff))
      else $error("entry count disagrees with valid bits");

   a_unique_match : assert property (@(posedge clock) disable iff (reset)
      $onehot0(match))
      else $error("handle present in more than one table entry");

   a_reset_empty : assert property (@(posedge clock)
      reset |=> !out_valid_ff && !skid_valid_ff && (valid_ff == '0))
      else $error("state not cleared by reset");
`endif

endmodule

### test/tb_iso_tx_header_and_credit_table.sv
// Testbench for iso_tx_header_and_credit_table: header fields, table full and
// the outstanding count per handle, checked against a cycle-free predictor.
// Depends on isotx_pkg and the block's RTL.
`timescale 1ns / 100ps

module tb_iso_tx_header_and_credit_table;
   import isotx_pkg::*;

   typedef struct {
      opcode_type            opcode;
      logic [HANDLE_W-1:0]   handle;
      logic [SEQ_W-1:0]      seq;
      logic                  ts;
      logic [SDU_W-1:0]      sdu;
      logic [COUNT_W-1:0]    count;
      logic                  last;
   } hci_req_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic                    req_opcode = 1'b0;
   logic [HANDLE_W-1:0]     req_conn_handle = '0;
   logic [SEQ_W-1:0]        req_seq_number = '0;
   logic                    req_ts_present = 1'b0;
   logic [SDU_W-1:0]        req_sdu_length = '0;
   logic [COUNT_W-1:0]      req_completed_count = '0;
   logic                    req_last_pair = 1'b0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [STATUS_W-1:0]     rsp_status;
   logic [WORD_W-1:0]       rsp_flags_handle_word;
   logic [LOAD_W-1:0]       rsp_load_length;
   logic [SEQ_W-1:0]        rsp_seq_out;
   logic [SDU_OUT_W-1:0]    rsp_sdu_len_out;
   logic [COUNT_W-1:0]      rsp_outstanding;
   logic [COUNT_W-1:0]      rsp_released_count;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [MAXLEN_W-1:0]     csr_data = '0;

   // predictor state
   logic [MAXLEN_W-1:0]     max_len;
   logic [HANDLE_W-1:0]     slot_handle [MAX_CONNECTIONS];
   logic                    slot_used [MAX_CONNECTIONS];
   logic [COUNT_W-1:0]      slot_count [MAX_CONNECTIONS];
   logic                    report_aborted;

   logic [HANDLE_W-1:0]     known_handles [MAX_CONNECTIONS];
   hci_req_type             pending [$];
   result_type              predicted [$];
   hci_req_type             cur_req;
   int                      send_idle_pct = 0;
   int                      stall_pct = 0;
   int                      fail_count = 0;
   logic                    hold_kick = 1'b0;
   int                      rsp_hold_left = 0;

   iso_tx_header_and_credit_table dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_opcode            (req_opcode),
      .req_conn_handle       (req_conn_handle),
      .req_seq_number        (req_seq_number),
      .req_ts_present        (req_ts_present),
      .req_sdu_length        (req_sdu_length),
      .req_completed_count   (req_completed_count),
      .req_last_pair         (req_last_pair),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_status            (rsp_status),
      .rsp_flags_handle_word (rsp_flags_handle_word),
      .rsp_load_length       (rsp_load_length),
      .rsp_seq_out           (rsp_seq_out),
      .rsp_sdu_len_out       (rsp_sdu_len_out),
      .rsp_outstanding       (rsp_outstanding),
      .rsp_released_count    (rsp_released_count),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_data              (csr_data)
   );

   always #10 clock = ~clock;

   function automatic result_type credit_step(input hci_req_type it);
      result_type r;
      int hit;
      int spare;
      r = '0;
      hit = -1;
      spare = -1;
      for (int i = 0; i < MAX_CONNECTIONS; i++) begin
         if (slot_used[i] && slot_handle[i] == it.handle && hit < 0) hit = i;
         if (!slot_used[i] && spare < 0) spare = i;
      end
      if (it.opcode == OP_SEND) begin
         if (it.sdu > {4'd0, max_len}) begin
            r.status = STATUS_TOO_LONG;
         end else begin
            r.flags_handle_word = {1'b0, it.ts, PB_COMPLETE, it.handle};
            r.load_length = it.sdu[LOAD_W-1:0] + (it.ts ? TS_HDR_LEN : NO_TS_HDR_LEN);
            r.seq_out = it.seq;
            r.sdu_len_out = it.sdu[SDU_OUT_W-1:0];
            if (hit < 0 && spare < 0) begin
               // packet still goes out, nothing is booked
               r.status = STATUS_FULL;
            end else begin
               if (hit < 0) begin
                  hit = spare;
                  slot_used[hit] = 1'b1;
                  slot_handle[hit] = it.handle;
                  slot_count[hit] = '0;
               end
               if (slot_count[hit] != COUNT_MAX) slot_count[hit] = slot_count[hit] + 1'b1;
               r.status = STATUS_OK;
               r.outstanding = slot_count[hit];
            end
         end
      end else begin
         if (report_aborted) begin
            r.status = STATUS_SKIPPED;
         end else if (hit < 0) begin
            r.status = STATUS_UNKNOWN;
            report_aborted = 1'b1;
         end else begin
            slot_count[hit] = (slot_count[hit] >= it.count) ? slot_count[hit] - it.count : '0;
            r.status = STATUS_OK;
            r.outstanding = slot_count[hit];
            r.released_count = it.count;
         end
         if (it.last) report_aborted = 1'b0;
      end
      credit_step = r;
   endfunction

   function automatic hci_req_type make_req(input opcode_type op,
                                            input logic [HANDLE_W-1:0] h,
                                            input logic [SEQ_W-1:0] seq, input logic ts,
                                            input logic [SDU_W-1:0] sdu,
                                            input logic [COUNT_W-1:0] cnt, input logic last);
      hci_req_type it;
      it.opcode = op;
      it.handle = h;
      it.seq = seq;
      it.ts = ts;
      it.sdu = sdu;
      it.count = cnt;
      it.last = last;
      make_req = it;
   endfunction

   function automatic logic [HANDLE_W-1:0] pick_handle();
      if ($urandom_range(99) < 80) pick_handle = known_handles[$urandom_range(MAX_CONNECTIONS-1)];
      else pick_handle = HANDLE_W'($urandom);
   endfunction

   function automatic logic [SDU_W-1:0] pick_sdu();
      case ($urandom_range(9))
         0: pick_sdu = SDU_W'($urandom);
         1: pick_sdu = {4'd0, max_len} + 1'b1;
         2: pick_sdu = {4'd0, max_len};
         default: pick_sdu = SDU_W'($urandom_range(max_len));
      endcase
   endfunction

   // sends and report events of one to four pairs; a few events are broken
   task automatic push_random(input int n);
      int pushed;
      int pairs;
      int shape;
      logic last;
      pushed = 0;
      while (pushed < n) begin
         if ($urandom_range(99) < 50) begin
            pending.push_back(make_req(OP_SEND, pick_handle(), SEQ_W'($urandom), 1'($urandom),
                                       pick_sdu(), COUNT_W'($urandom), 1'($urandom)));
            pushed++;
         end else begin
            pairs = $urandom_range(1, 4);
            shape = $urandom_range(19);
            for (int i = 0; i < pairs; i++) begin
               if (shape == 0) last = 1'($urandom);
               else if (shape == 1) last = 1'b0;
               else last = (i == pairs - 1);
               pending.push_back(make_req(OP_REPORT, pick_handle(), SEQ_W'($urandom),
                                          1'($urandom), SDU_W'($urandom),
                                          ($urandom_range(3) == 0) ? COUNT_W'($urandom)
                                                                   : COUNT_W'($urandom_range(3)),
                                          last));
            end
            pushed += pairs;
         end
      end
   endtask

   // sampled at the falling edge, clear of the updates made at the rising edge
   task automatic wait_drained();
      while (pending.size() != 0 || req_valid || predicted.size() != 0) @(negedge clock);
   endtask

   task automatic write_max_len(input logic [MAXLEN_W-1:0] v);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      max_len = v;
   endtask

   always @(posedge clock) begin : req_driver
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) predicted.push_back(credit_step(cur_req));
         if (!req_valid || !req_stall) begin
            if (pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               cur_req = pending.pop_front();
               req_valid <= 1'b1;
               req_opcode <= cur_req.opcode;
               req_conn_handle <= cur_req.handle;
               req_seq_number <= cur_req.seq;
               req_ts_present <= cur_req.ts;
               req_sdu_length <= cur_req.sdu;
               req_completed_count <= cur_req.count;
               req_last_pair <= cur_req.last;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : hold_counter
      if (reset) rsp_hold_left <= 0;
      else if (hold_kick) rsp_hold_left <= 80;
      else if (rsp_hold_left != 0) rsp_hold_left <= rsp_hold_left - 1;
   end

   always @(posedge clock) begin : rsp_monitor
      result_type want;
      result_type got;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got.status = status_type'(rsp_status);
            got.flags_handle_word = rsp_flags_handle_word;
            got.load_length = rsp_load_length;
            got.seq_out = rsp_seq_out;
            got.sdu_len_out = rsp_sdu_len_out;
            got.outstanding = rsp_outstanding;
            got.released_count = rsp_released_count;
            if (predicted.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) $display("result transfer with nothing expected");
            end else begin
               want = predicted.pop_front();
               if (got.status !== want.status ||
                   got.flags_handle_word !== want.flags_handle_word ||
                   got.load_length !== want.load_length ||
                   got.seq_out !== want.seq_out ||
                   got.sdu_len_out !== want.sdu_len_out ||
                   got.outstanding !== want.outstanding ||
                   got.released_count !== want.released_count) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $write("mismatch exp/act: status %0d/%0d word %h/%h load %h/%h",
                            want.status, got.status,
                            want.flags_handle_word, got.flags_handle_word,
                            want.load_length, got.load_length);
                     $display(" seq %h/%h sdu %h/%h outst %h/%h rel %h/%h",
                              want.seq_out, got.seq_out,
                              want.sdu_len_out, got.sdu_len_out,
                              want.outstanding, got.outstanding,
                              want.released_count, got.released_count);
                  end
               end
            end
         end
         rsp_stall <= (rsp_hold_left != 0) || ($urandom_range(99) < stall_pct);
      end
   end

   initial begin : stimulus
      max_len = MAX_DATA_LEN_RESET;
      report_aborted = 1'b0;
      for (int i = 0; i < MAX_CONNECTIONS; i++) begin
         slot_handle[i] = '0;
         slot_used[i] = 1'b0;
         slot_count[i] = '0;
      end
      known_handles[0] = 12'h000;
      known_handles[1] = 12'hFFF;
      known_handles[2] = 12'h5A5;
      known_handles[3] = 12'hA5A;
      known_handles[4] = 12'h123;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: empty table, length limit, table filling up, abort handling
      pending.push_back(make_req(OP_REPORT, 12'h123, 16'h0000, 1'b0, 16'h0000, 16'd5, 1'b1));
      pending.push_back(make_req(OP_SEND, 12'h000, 16'h0000, 1'b0, 16'h0000, 16'h0000, 1'b0));
      pending.push_back(make_req(OP_SEND, 12'hFFF, 16'hFFFF, 1'b1, 16'd4095, 16'hFFFF, 1'b1));
      pending.push_back(make_req(OP_SEND, 12'h5A5, 16'h1234, 1'b1, 16'd4096, 16'h0000, 1'b0));
      pending.push_back(make_req(OP_SEND, 12'h5A5, 16'h8001, 1'b0, 16'hFFFF, 16'h0000, 1'b0));
      pending.push_back(make_req(OP_SEND, 12'h5A5, 16'h0042, 1'b0, 16'd1234, 16'h0000, 1'b0));
      pending.push_back(make_req(OP_SEND, 12'hA5A, 16'h7FFF, 1'b1, 16'd1, 16'h0000, 1'b0));
      pending.push_back(make_req(OP_SEND, 12'h123, 16'h0001, 1'b0, 16'd77, 16'h0000, 1'b0));
      pending.push_back(make_req(OP_SEND, 12'h777, 16'h0002, 1'b1, 16'd300, 16'h0000, 1'b0));
      pending.push_back(make_req(OP_SEND, 12'h000, 16'h0003, 1'b1, 16'd0, 16'h0000, 1'b0));
      pending.push_back(make_req(OP_REPORT, 12'h000, 16'h0000, 1'b0, 16'h0000, 16'd1, 1'b0));
      pending.push_back(make_req(OP_REPORT, 12'hFFF, 16'hFFFF, 1'b1, 16'hFFFF, 16'hFFFF, 1'b0));
      pending.push_back(make_req(OP_REPORT, 12'h456, 16'h0000, 1'b0, 16'h0000, 16'd1, 1'b0));
      pending.push_back(make_req(OP_REPORT, 12'h000, 16'h0000, 1'b0, 16'h0000, 16'd1, 1'b0));
      pending.push_back(make_req(OP_REPORT, 12'h000, 16'h0000, 1'b0, 16'h0000, 16'd1, 1'b1));
      pending.push_back(make_req(OP_REPORT, 12'h999, 16'h0000, 1'b0, 16'h0000, 16'd2, 1'b0));
      // a send inside an aborted event leaves the abort standing
      pending.push_back(make_req(OP_SEND, 12'h000, 16'hBEEF, 1'b0, 16'd10, 16'h0000, 1'b1));
      pending.push_back(make_req(OP_REPORT, 12'h000, 16'h0000, 1'b0, 16'h0000, 16'd1, 1'b1));
      pending.push_back(make_req(OP_REPORT, 12'h000, 16'h0000, 1'b0, 16'h0000, 16'd0, 1'b1));
      pending.push_back(make_req(OP_REPORT, 12'h888, 16'h0000, 1'b0, 16'h0000, 16'd3, 1'b1));
      pending.push_back(make_req(OP_REPORT, 12'h5A5, 16'h0000, 1'b0, 16'h0000, 16'd7, 1'b1));
      wait_drained();

      // receiver holds off for a long stretch while the sender keeps offering
      push_random(250);
      @(posedge clock);
      hold_kick <= 1'b1;
      @(posedge clock);
      hold_kick <= 1'b0;
      wait_drained();

      write_max_len(12'd0);
      send_idle_pct = 57;
      push_random(200);
      wait_drained();

      write_max_len(MAXLEN_W'($urandom_range(1, 4094)));
      send_idle_pct = 0;
      stall_pct = 57;
      push_random(200);
      wait_drained();

      write_max_len(12'hFFF);
      send_idle_pct = 26;
      stall_pct = 26;
      push_random(200);
      wait_drained();

      write_max_len(12'd1);
      send_idle_pct = 26;
      stall_pct = 26;
      push_random(150);
      wait_drained();

      repeat (10) @(posedge clock);
      if (fail_count == 0 && predicted.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin : watchdog
      #10_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
